// File: design/dvg_pkg.sv
package dvg_pkg;

    // fixed field widths of the streams and the register port
    localparam int GRID_W   = 6;
    localparam int SCALE_W  = 31;
    localparam int NODE_W   = 5;
    localparam int P_IN_W   = 32;
    localparam int VEL_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 96;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_NX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_NY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_NZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

    // request kinds carried on tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // reset values of the registers
    localparam logic [GRID_W-1:0]  GRID_RESET  = 6'd32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd65536;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // control that travels with a neighbour pair through the velocity unit
    typedef struct packed {
        logic  valid;
        t_axis axis;
    } t_vel_ctl;

endpackage

// File: design/dvg_store.sv
module dvg_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // single port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dvg_vel.sv
module dvg_vel import dvg_pkg::*; #(
    parameter int PW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_vel_ctl             i_ctl,
    input  logic signed [PW-1:0] i_p_next,
    input  logic signed [PW-1:0] i_p_prev,
    input  logic [SCALE_W-1:0]   i_scale,
    output t_vel_ctl             o_ctl,
    output logic [VEL_W-1:0]     o_vel,
    output logic                 o_sat
);

    localparam int DW  = PW + 1;
    localparam int MW  = (DW > 33) ? DW : 33;
    localparam int HW  = MW - 32;
    localparam int PHW = HW + SCALE_W;
    localparam int RW  = MW + 17;

    localparam logic [RW-1:0] NEG_LIMIT = RW'(64'h0000_0000_8000_0000);
    localparam logic [RW-1:0] POS_LIMIT = RW'(64'h0000_0000_7FFF_FFFF);

    t_vel_ctl              r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl;
    logic signed [DW-1:0]  r1_d;
    logic [SCALE_W-1:0]    r1_scale, r2_scale;
    logic [MW-1:0]         r2_mag;
    logic                  r2_pos, r3_pos, r4_pos;
    logic [63:0]           r3_pl;
    logic [PHW-1:0]        r3_ph;
    logic [RW-1:0]         r4_r;
    logic [VEL_W-1:0]      r5_vel;
    logic                  r5_sat;

    logic signed [DW-1:0]  n_d;
    logic [DW-1:0]         abs_d;
    logic [63:0]           pl_rnd;

    // exact difference of the neighbours
    assign n_d = {i_p_next[PW-1], i_p_next} - {i_p_prev[PW-1], i_p_prev};

    // magnitude of the difference
    assign abs_d = r1_d[DW-1] ? DW'(DW'(0) - r1_d) : DW'(r1_d);

    // round the low product before the shift
    assign pl_rnd = r3_pl + 64'h0000_0000_0000_8000;

    // control (valid and axis) of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    // datapath: difference, magnitude, products, sum, negation and saturation
    always_ff @(posedge i_clk) begin
        r1_d     <= n_d;
        r1_scale <= i_scale;

        r2_mag   <= MW'(abs_d);
        r2_pos   <= !r1_d[DW-1] && (r1_d != '0);
        r2_scale <= r1_scale;

        r3_pl    <= 64'(r2_mag[31:0]) * 64'(r2_scale);
        r3_ph    <= PHW'(r2_mag[MW-1:32]) * PHW'(r2_scale);
        r3_pos   <= r2_pos;

        r4_r     <= RW'({r3_ph, 16'h0000}) + RW'(pl_rnd[63:16]);
        r4_pos   <= r3_pos;

        if (r4_pos) begin
            if (r4_r > NEG_LIMIT) begin
                r5_vel <= 32'h8000_0000;
                r5_sat <= 1'b1;
            end else begin
                r5_vel <= ~r4_r[VEL_W-1:0] + 32'd1;
                r5_sat <= 1'b0;
            end
        end else begin
            if (r4_r > POS_LIMIT) begin
                r5_vel <= 32'h7FFF_FFFF;
                r5_sat <= 1'b1;
            end else begin
                r5_vel <= r4_r[VEL_W-1:0];
                r5_sat <= 1'b0;
            end
        end
    end

    assign o_ctl = r5_ctl;
    assign o_vel = r5_vel;
    assign o_sat = r5_sat;

endmodule

// File: design/darcy_velocity_gradient_3d_top.sv
// load: accepted in idle, written to the grid memory in ST_WRITE after ST_ADDR, then back to idle for the next request
// query: result in the output register after ST_ADDR, ST_READ, ST_DRAIN and ST_FIN; no new request until back in idle;
//   ST_READ makes six reads through the single grid memory port into the five-stage velocity unit
// a new request is taken while a finished result still waits in the output register
// reset (synchronous, active low) restores the registers and clears control;
//   grid memory content stays undefined until loaded
module darcy_velocity_gradient_3d_top import dvg_pkg::*; #(
    parameter int MAX_DIM        = 32,
    parameter int PRESSURE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,  // node_i[4:0], node_j[9:5], node_k[14:10],
                                             // pressure[46:15], zero[47]
    input  logic                 i_s_tuser,  // req_type
    // master side result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_DATA_W-1:0]  o_m_tdata,  // vel_x[31:0], vel_y[63:32], vel_z[95:64]
    output logic                 o_m_tuser,  // saturated
    // register write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int PW    = PRESSURE_WIDTH;
    localparam int IW    = $clog2(MAX_DIM);
    localparam int CW    = $clog2(MAX_DIM + 64);
    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (PW > P_IN_W) ? PW : P_IN_W;

    localparam logic [AW-1:0] STRIDE_J = AW'(MAX_DIM);
    localparam logic [AW-1:0] STRIDE_K = AW'(MAX_DIM * MAX_DIM);
    localparam logic [CW-1:0] DIM_C    = CW'(MAX_DIM);

    localparam logic signed [XW-1:0] P_HI = (XW'(1) <<< (PW - 1)) - XW'(1);
    localparam logic signed [XW-1:0] P_LO = -P_HI - XW'(1);

    // neighbour read order
    localparam logic [2:0] SLOT_XN = 3'd0;
    localparam logic [2:0] SLOT_XP = 3'd1;
    localparam logic [2:0] SLOT_YN = 3'd2;
    localparam logic [2:0] SLOT_YP = 3'd3;
    localparam logic [2:0] SLOT_ZN = 3'd4;
    localparam logic [2:0] SLOT_ZP = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_FIN
    } t_state;

    t_state               r_state;
    logic [2:0]           r_slot;
    logic                 r_rd_vld;
    logic [2:0]           r_rd_slot;
    logic                 r_req_type;
    logic [NODE_W-1:0]    r_node_i, r_node_j, r_node_k;
    logic [P_IN_W-1:0]    r_pressure;
    logic [IW-1:0]        r_ci, r_cj, r_ck;
    logic [PW-1:0]        r_p_next;
    logic [VEL_W-1:0]     r_vx, r_vy, r_vz;
    logic                 r_sat_acc;
    logic                 r_m_valid;
    logic [M_DATA_W-1:0]  r_m_data;
    logic                 r_m_sat;

    logic [GRID_W-1:0]    r_grid_nx, r_grid_ny, r_grid_nz;
    logic [SCALE_W-1:0]   r_scale_x, r_scale_y, r_scale_z;

    logic [CW-1:0]        ext_x, ext_y, ext_z;
    logic [IW-1:0]        nb_i, nb_j, nb_k;
    logic                 s_acc;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [PW-1:0]        mem_wdata;
    logic [PW-1:0]        mem_rdata;
    logic signed [XW-1:0] p_ext;
    logic signed [XW-1:0] p_sat;
    t_vel_ctl             u_in_ctl;
    t_vel_ctl             u_out_ctl;
    logic [SCALE_W-1:0]   u_scale;
    logic [VEL_W-1:0]     u_vel;
    logic                 u_sat;

    // extent in use: zero acts as one, capped at the grid size
    function automatic logic [CW-1:0] f_extent(input logic [GRID_W-1:0] n);
        logic [CW-1:0] w;
        w = CW'(n);
        if (w == '0) begin
            return CW'(1);
        end else if (w > DIM_C) begin
            return DIM_C;
        end
        return w;
    endfunction

    function automatic logic [IW-1:0] f_clamp(input logic [NODE_W-1:0] v,
                                              input logic [CW-1:0] ext);
        if (CW'(v) >= ext) begin
            return IW'(ext - CW'(1));
        end
        return IW'(v);
    endfunction

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] ext);
        logic [CW-1:0] up;
        up = CW'(idx) + CW'(1);
        if (up >= ext) begin
            return idx;
        end
        return IW'(up);
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] idx);
        if (idx == '0) begin
            return idx;
        end
        return idx - IW'(1);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] i,
                                             input logic [IW-1:0] j,
                                             input logic [IW-1:0] k);
        return AW'(i) + STRIDE_J * AW'(j) + STRIDE_K * AW'(k);
    endfunction

    assign ext_x = f_extent(r_grid_nx);
    assign ext_y = f_extent(r_grid_ny);
    assign ext_z = f_extent(r_grid_nz);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_nx <= GRID_RESET;
            r_grid_ny <= GRID_RESET;
            r_grid_nz <= GRID_RESET;
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
            r_scale_z <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GRID_NX: r_grid_nx <= i_cfg_data[GRID_W-1:0];
                REG_GRID_NY: r_grid_ny <= i_cfg_data[GRID_W-1:0];
                REG_GRID_NZ: r_grid_nz <= i_cfg_data[GRID_W-1:0];
                REG_SCALE_X: r_scale_x <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Y: r_scale_y <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_Z: r_scale_z <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // neighbour node for the current read slot
    always_comb begin
        nb_i = r_ci;
        nb_j = r_cj;
        nb_k = r_ck;
        case (r_slot)
            SLOT_XN: nb_i = f_next(r_ci, ext_x);
            SLOT_XP: nb_i = f_prev(r_ci);
            SLOT_YN: nb_j = f_next(r_cj, ext_y);
            SLOT_YP: nb_j = f_prev(r_cj);
            SLOT_ZN: nb_k = f_next(r_ck, ext_z);
            SLOT_ZP: nb_k = f_prev(r_ck);
            default: ;
        endcase
    end

    // load value limited to the stored width
    always_comb begin
        p_ext = XW'(signed'(r_pressure));
        p_sat = p_ext;
        if (p_ext > P_HI) begin
            p_sat = P_HI;
        end else if (p_ext < P_LO) begin
            p_sat = P_LO;
        end
    end

    assign mem_we    = (r_state == ST_WRITE);
    assign mem_addr  = mem_we ? f_addr(r_ci, r_cj, r_ck) : f_addr(nb_i, nb_j, nb_k);
    assign mem_wdata = PW'(p_sat);

    dvg_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // pair complete when the previous neighbour returns
    always_comb begin
        u_in_ctl.valid = r_rd_vld && r_rd_slot[0];
        case (r_rd_slot[2:1])
            2'd0:    u_in_ctl.axis = AXIS_X;
            2'd1:    u_in_ctl.axis = AXIS_Y;
            default: u_in_ctl.axis = AXIS_Z;
        endcase
        case (u_in_ctl.axis)
            AXIS_X:  u_scale = r_scale_x;
            AXIS_Y:  u_scale = r_scale_y;
            default: u_scale = r_scale_z;
        endcase
    end

    dvg_vel #(
        .PW (PW)
    ) u_vel_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (u_in_ctl),
        .i_p_next (signed'(r_p_next)),
        .i_p_prev (signed'(mem_rdata)),
        .i_scale  (u_scale),
        .o_ctl    (u_out_ctl),
        .o_vel    (u_vel),
        .o_sat    (u_sat)
    );

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_slot    <= SLOT_XN;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == ST_READ);
            r_rd_slot <= r_slot;

            // output valid: set by a finished query, cleared when taken
            if (r_state == ST_FIN && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            if (r_rd_vld && !r_rd_slot[0]) begin
                r_p_next <= mem_rdata;
            end

            // collect axis results
            if (u_out_ctl.valid) begin
                r_sat_acc <= r_sat_acc | u_sat;
                case (u_out_ctl.axis)
                    AXIS_X:  r_vx <= u_vel;
                    AXIS_Y:  r_vy <= u_vel;
                    default: r_vz <= u_vel;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_req_type <= i_s_tuser;
                        r_node_i   <= i_s_tdata[4:0];
                        r_node_j   <= i_s_tdata[9:5];
                        r_node_k   <= i_s_tdata[14:10];
                        r_pressure <= i_s_tdata[46:15];
                        r_sat_acc  <= 1'b0;
                        r_state    <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_ci   <= f_clamp(r_node_i, ext_x);
                    r_cj   <= f_clamp(r_node_j, ext_y);
                    r_ck   <= f_clamp(r_node_k, ext_z);
                    r_slot <= SLOT_XN;
                    r_state <= (r_req_type == REQ_LOAD) ? ST_WRITE : ST_READ;
                end
                ST_WRITE: begin
                    r_state <= ST_IDLE;
                end
                ST_READ: begin
                    if (r_slot == SLOT_ZP) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_slot <= r_slot + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    if (u_out_ctl.valid && u_out_ctl.axis == AXIS_Z) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_data  <= {r_vz, r_vy, r_vx};
                        r_m_sat   <= r_sat_acc;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_sat;

    // velocity results only come back while a query drains
    a_vel_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_out_ctl.valid |-> r_state == ST_DRAIN)
        else $error("velocity result outside query drain");

    // an accepted load reaches the memory in ST_WRITE, after ST_ADDR
    a_load_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tuser == REQ_LOAD) |=> ##1 mem_we)
        else $error("load not written to grid memory");

    // read slot never runs past the last neighbour
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_ZP)
        else $error("read slot out of range");

    // a finished query with a free output register is presented next cycle
    a_fin_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_m_valid) |=> o_m_tvalid)
        else $error("finished query not presented");

endmodule

// File: test/darcy_velocity_gradient_3d_top_tb.sv
module darcy_velocity_gradient_3d_top_tb import dvg_pkg::*;;

    localparam int GRID_MAX    = 32;
    localparam int ITEM_TARGET = 750;
    localparam int DRAIN       = 20;

    // indexes past the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic                 o_m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    darcy_velocity_gradient_3d_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // one expected query answer: three components and the clip flag
    typedef struct packed {
        logic            sat;
        logic [2:0][31:0] v;
    } t_darcy_result;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
    } t_reg_write;

    // shadow of the pressure grid and registers, predicts each velocity
    class grid_velocity_board;
        int            pstore [GRID_MAX*GRID_MAX*GRID_MAX];
        logic [5:0]    dim [3];
        logic [30:0]   scl [3];
        string         axis_name [3];
        t_darcy_result velocity_due [$];
        int            mismatches;
        int            loads;
        int            queries;
        int            sat_seen;

        function new();
            dim        = '{GRID_RESET, GRID_RESET, GRID_RESET};
            scl        = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};
            axis_name  = '{"vel_x", "vel_y", "vel_z"};
            mismatches = 0;
            loads      = 0;
            queries    = 0;
            sat_seen   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_GRID_NX: dim[0] = val[5:0];
                REG_GRID_NY: dim[1] = val[5:0];
                REG_GRID_NZ: dim[2] = val[5:0];
                REG_SCALE_X: scl[0] = val[30:0];
                REG_SCALE_Y: scl[1] = val[30:0];
                REG_SCALE_Z: scl[2] = val[30:0];
                default: ;
            endcase
        endfunction

        // extent in use: zero acts as one, anything past the grid as the grid
        function int span(logic [5:0] n);
            if (n == 0) return 1;
            if (n > GRID_MAX) return GRID_MAX;
            return int'(n);
        endfunction

        function int node_addr(int c [3]);
            return c[0] + GRID_MAX * (c[1] + GRID_MAX * c[2]);
        endfunction

        // rounded, negated, saturated product; bit 32 flags a clip
        function logic [32:0] axis_velocity(longint d, logic [30:0] s);
            longint unsigned mag;
            longint unsigned r;
            mag = (d < 0) ? -d : d;
            r = (mag * s + 64'h8000) >> 16;
            if (d > 0) begin
                if (r > 64'h8000_0000) return {1'b1, 32'h8000_0000};
                return {1'b0, 32'(-r)};
            end
            if (r > 64'h7fff_ffff) return {1'b1, 32'h7fff_ffff};
            return {1'b0, 32'(r)};
        endfunction

        function void take_request(logic req, logic [4:0] ni, logic [4:0] nj,
                                   logic [4:0] nk, logic [31:0] p);
            int            n [3];
            int            c [3];
            int            hi_n [3];
            int            lo_n [3];
            logic [4:0]    raw [3];
            logic [32:0]   vr;
            t_darcy_result r;
            raw   = '{ni, nj, nk};
            r.sat = 1'b0;
            for (int a = 0; a < 3; a++) begin
                n[a] = span(dim[a]);
                c[a] = (int'(raw[a]) >= n[a]) ? n[a] - 1 : int'(raw[a]);
            end
            if (req == REQ_LOAD) begin
                pstore[node_addr(c)] = p;
                loads++;
                return;
            end
            // clamped neighbours on each axis
            for (int a = 0; a < 3; a++) begin
                hi_n = c;
                lo_n = c;
                if (c[a] + 1 < n[a]) hi_n[a] = c[a] + 1;
                if (c[a] > 0) lo_n[a] = c[a] - 1;
                vr = axis_velocity(longint'(pstore[node_addr(hi_n)]) -
                                   longint'(pstore[node_addr(lo_n)]), scl[a]);
                r.v[a] = vr[31:0];
                r.sat  = r.sat | vr[32];
            end
            queries++;
            velocity_due = {velocity_due, r};
        endfunction

        function void check_velocity(logic [M_DATA_W-1:0] data, logic sat);
            t_darcy_result e;
            logic [31:0]   got;
            if (velocity_due.size() == 0) begin
                $error("velocity result with no query waiting");
                mismatches++;
                return;
            end
            e = velocity_due.pop_front();
            if (e.sat) sat_seen++;
            for (int a = 0; a < 3; a++) begin
                got = data[32*a +: 32];
                if (got !== e.v[a]) begin
                    $error("%s expected %0d got %0d", axis_name[a],
                           $signed(e.v[a]), $signed(got));
                    mismatches++;
                end
            end
            if (sat !== e.sat) begin
                $error("saturated expected %0b got %0b", e.sat, sat);
                mismatches++;
            end
        endfunction

        function int pending();
            return velocity_due.size();
        endfunction
    endclass

    grid_velocity_board sb;
    t_reg_write         reg_plan [$];
    bit                 calm       = 1'b0;
    int                 out_hold   = 0;
    int                 items_sent = 0;
    int                 settings_n = 0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_pressure();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7fff_ffff;
        if (r == 1) return 32'h8000_0000;
        if (r < 5) return $urandom_range(0, 32'h3ffff) - 32'h20000;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'h7fff_ffff;
        if (r == 2) return 32'hffff_ffff;
        if (r < 7) return $urandom_range(0, 32'h3ffff);
        return $urandom;
    endfunction

    // small extents, sometimes zero, sometimes with junk above the field
    function automatic logic [31:0] pick_dim();
        logic [31:0] v;
        v      = $urandom;
        v[5:0] = ($urandom_range(0, 7) == 0) ? 6'd0 : 6'($urandom_range(1, 5));
        if ($urandom_range(0, 3) != 0) v[31:6] = '0;
        return v;
    endfunction

    function automatic logic [4:0] pick_node(int n);
        if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, n - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    // result side: take results, stall at random
    always @(posedge i_clk) begin : result_side
        int n;
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_velocity(o_m_tdata, o_m_tuser);
        if (out_hold != 0) begin
            out_hold   <= out_hold - 1;
            i_m_tready <= 1'b0;
        end else begin
            n          = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            i_m_tready <= (n == 0);
            out_hold   <= (n > 0) ? n - 1 : 0;
        end
    end

    // one request; valid stays high when the next follows without a gap
    task automatic send_request(logic req, logic [4:0] ni, logic [4:0] nj,
                                logic [4:0] nk, logic [31:0] p);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {1'b0, p, nk, nj, ni};
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_request(req, ni, nj, nk, p);
        items_sent++;
    endtask

    task automatic plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        t_reg_write w;
        w.idx = idx;
        w.val = val;
        reg_plan = {reg_plan, w};
    endtask

    task automatic apply_regs();
        t_reg_write w;
        while (reg_plan.size() != 0) begin
            w = reg_plan.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.val;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(w.idx, w.val);
        end
        i_cfg_valid <= 1'b0;
        settings_n++;
    endtask

    // stop requesting, wait for every answer, then let a trailing load finish
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // new setting, full grid load, then a random mix of loads and queries
    task automatic run_phase(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             int mixed);
        int ex;
        int ey;
        int ez;
        settle();
        plan_reg(REG_GRID_NX, gx);
        plan_reg(REG_GRID_NY, gy);
        plan_reg(REG_GRID_NZ, gz);
        if ($urandom_range(0, 2) == 0)
            plan_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        plan_reg(REG_SCALE_X, sx);
        plan_reg(REG_SCALE_Y, sy);
        plan_reg(REG_SCALE_Z, sz);
        apply_regs();
        calm = ($urandom_range(0, 3) == 0);
        ex = sb.span(gx[5:0]);
        ey = sb.span(gy[5:0]);
        ez = sb.span(gz[5:0]);
        for (int k = 0; k < ez; k++)
            for (int j = 0; j < ey; j++)
                for (int i = 0; i < ex; i++)
                    send_request(REQ_LOAD, 5'(i), 5'(j), 5'(k), pick_pressure());
        repeat (mixed) begin
            if ($urandom_range(0, 99) < 55)
                send_request(REQ_QUERY, pick_node(ex), pick_node(ey), pick_node(ez), $urandom);
            else
                send_request(REQ_LOAD, pick_node(ex), pick_node(ey), pick_node(ez),
                             pick_pressure());
        end
    endtask

    // stimulus
    initial begin : stimulus
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2x2 grid at reset scales, extreme pressures, clamped load indexes
        plan_reg(REG_GRID_NX, 32'd2);
        plan_reg(REG_GRID_NY, 32'd2);
        plan_reg(REG_GRID_NZ, 32'd2);
        apply_regs();
        send_request(REQ_LOAD, 5'd0, 5'd0, 5'd0, 32'h7fff_ffff);
        send_request(REQ_LOAD, 5'd31, 5'd0, 5'd0, 32'h8000_0000);
        send_request(REQ_LOAD, 5'd0, 5'd31, 5'd0, 32'h8000_0000);
        send_request(REQ_LOAD, 5'd0, 5'd0, 5'd31, 32'h0001_0000);
        send_request(REQ_LOAD, 5'd1, 5'd1, 5'd0, 32'h0);
        send_request(REQ_LOAD, 5'd1, 5'd0, 5'd1, 32'hffff_ffff);
        send_request(REQ_LOAD, 5'd0, 5'd1, 5'd1, 32'h1);
        send_request(REQ_LOAD, 5'd31, 5'd31, 5'd31, 32'h1234_5678);
        send_request(REQ_QUERY, 5'd0, 5'd0, 5'd0, 32'h0);
        send_request(REQ_QUERY, 5'd1, 5'd0, 5'd0, 32'hffff_ffff);
        send_request(REQ_QUERY, 5'd31, 5'd31, 5'd31, 32'h0);
        send_request(REQ_QUERY, 5'd0, 5'd1, 5'd0, 32'h0);
        send_request(REQ_QUERY, 5'd1, 5'd1, 5'd0, 32'h0);

        // rounding ties, scale with the top bit set, zero scale, single-node z
        settle();
        plan_reg(REG_GRID_NX, 32'd2);
        plan_reg(REG_GRID_NY, 32'd2);
        plan_reg(REG_GRID_NZ, 32'd1);
        plan_reg(REG_SPARE_A, 32'hffff_ffff);
        plan_reg(REG_SPARE_B, 32'h0);
        plan_reg(REG_SCALE_X, 32'd32768);
        plan_reg(REG_SCALE_Y, 32'hffff_ffff);
        plan_reg(REG_SCALE_Z, 32'h0);
        apply_regs();
        send_request(REQ_LOAD, 5'd0, 5'd0, 5'd0, 32'h0);
        send_request(REQ_LOAD, 5'd1, 5'd0, 5'd0, 32'h3);
        send_request(REQ_LOAD, 5'd0, 5'd1, 5'd0, 32'h7fff_ffff);
        send_request(REQ_LOAD, 5'd1, 5'd1, 5'd0, 32'hffff_fffd);
        send_request(REQ_QUERY, 5'd0, 5'd0, 5'd0, 32'h0);
        send_request(REQ_QUERY, 5'd1, 5'd1, 5'd0, 32'h0);
        send_request(REQ_QUERY, 5'd31, 5'd0, 5'd9, 32'h0);

        // extreme extents, then random settings
        run_phase(32'd1, 32'd1, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 20);
        run_phase(32'd0, 32'd63, 32'd3, 32'h0, 32'h7fff_ffff, $urandom, 30);
        run_phase(32'd32, 32'd1, 32'd2, pick_scale(), pick_scale(), pick_scale(), 30);
        run_phase(32'd1, 32'd2, 32'd32, pick_scale(), pick_scale(), pick_scale(), 30);
        while (items_sent < ITEM_TARGET)
            run_phase(pick_dim(), pick_dim(), pick_dim(), pick_scale(), pick_scale(),
                      pick_scale(), $urandom_range(30, 70));

        settle();
        $display("covered %0d loads and %0d queries over %0d register settings",
                 sb.loads, sb.queries, settings_n);
        $display("%0d velocity results were clipped", sb.sat_seen);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
design/dvg_pkg.sv
design/dvg_store.sv
design/dvg_vel.sv
design/darcy_velocity_gradient_3d_top.sv
test/darcy_velocity_gradient_3d_top_tb.sv
